// ----- rtl/utf8v_pkg.sv -----
// utf8v_pkg: shared types and constants of the UTF-8 prefix validator.
// No dependencies; used by the interfaces, utf8v_step and the top level.
package utf8v_pkg;

  localparam int unsigned LenW   = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned MaskW  = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [2:0] {
    REASON_RUNNING   = 3'd0,
    REASON_BUF_END   = 3'd1,
    REASON_MALFORMED = 3'd2,
    REASON_CONTROL   = 3'd3,
    REASON_CHAR_LIM  = 3'd4
  } stop_reason_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONTROL_MASK   = 2'd0,
    CFG_LIMIT_BY_CHARS = 2'd1,
    CFG_CHAR_LIMIT     = 2'd2
  } cfg_index_t;

  localparam logic [7:0] TopBit   = 8'h80;
  localparam logic [7:0] LeadBits = 8'hC0;
  localparam logic [7:0] ContBit  = 8'h40;
  localparam logic [7:0] CtrlTop  = 8'h20;
  localparam logic [2:0] MaxBytes = 3'd4;

  typedef struct packed {
    logic                stopped;
    logic [LenW-1:0]     committed;
    logic [2:0]          pending;
    logic [7:0]          lead_bits;
    logic [CountW-1:0]   char_count;
    stop_reason_t        reason;
  } scan_state_t;

  typedef struct packed {
    logic [LenW-1:0]     valid_length;
    logic                scan_done;
    stop_reason_t        stop_reason;
    logic                buffer_end;
  } scan_result_t;

  typedef struct packed {
    logic [MaskW-1:0]    control_mask;
    logic                limit_by_chars;
    logic [CountW-1:0]   char_limit;
  } scan_cfg_t;

endpackage

// ----- rtl/utf8v_if.sv -----
// utf8v_if: valid/ready channels of the UTF-8 prefix validator.
// Depends on utf8v_pkg for field widths.
interface utf8v_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_result_if import utf8v_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [LenW-1:0] valid_length;
  logic            scan_done;
  logic [2:0]      stop_reason;
  logic            buffer_end;
  modport source (output valid, output valid_length, output scan_done,
                  output stop_reason, output buffer_end, input ready);
  modport sink (input valid, input valid_length, input scan_done,
                input stop_reason, input buffer_end, output ready);
endinterface

interface utf8v_cfg_if import utf8v_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [MaskW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/utf8_prefix_validator_core.sv -----
// utf8_prefix_validator_core: one result word per input byte, from a registered output.
// The result is registered and valid in the cycle after the byte is accepted.
// One byte per cycle unless results stall; scan state updates on the accepting edge.
// Reset (rst, sync, active high) clears scan state, output valid and config registers.
// Depends on utf8v_pkg, utf8v_if and utf8v_step.
module utf8_prefix_validator_core import utf8v_pkg::*; #(
  parameter int unsigned MAX_BUFFER_BYTES = 65535
) (
  input  logic                  clk,
  input  logic                  rst,
  utf8v_byte_if.sink            scan_bytes,
  utf8v_result_if.source        scan_results,
  utf8v_cfg_if.sink             cfg
);

  localparam logic [LenW:0] LenCap = (MAX_BUFFER_BYTES < 65535) ?
                                     (LenW+1)'(MAX_BUFFER_BYTES) : (LenW+1)'(65535);

  scan_cfg_t    cfg_regs;
  scan_state_t  state;
  scan_state_t  state_next;
  scan_result_t res_next;
  scan_result_t res_q;
  logic         out_valid;
  logic         accept;

  assign cfg.ready        = 1'b1;
  assign scan_bytes.ready = !out_valid || scan_results.ready;
  assign accept           = scan_bytes.valid && scan_bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_CONTROL_MASK:   cfg_regs.control_mask   <= cfg.data;
        CFG_LIMIT_BY_CHARS: cfg_regs.limit_by_chars <= cfg.data[0];
        CFG_CHAR_LIMIT:     cfg_regs.char_limit     <= cfg.data[CountW-1:0];
        default: ;
      endcase
    end
  end

  utf8v_step #(.LEN_CAP(LenCap)) u_step (
    .cur       (state),
    .cfg       (cfg_regs),
    .data_byte (scan_bytes.data_byte),
    .last_byte (scan_bytes.last_byte),
    .nxt       (state_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (scan_results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_next;
    end
  end

  assign scan_results.valid        = out_valid;
  assign scan_results.valid_length = res_q.valid_length;
  assign scan_results.scan_done    = res_q.scan_done;
  assign scan_results.stop_reason  = res_q.stop_reason;
  assign scan_results.buffer_end   = res_q.buffer_end;

`ifndef SYNTHESIS
  a_pending_max: assert property (@(posedge clk) disable iff (rst)
    state.pending <= MaxBytes)
    else $error("open character longer than four bytes");

  a_stopped_clean: assert property (@(posedge clk) disable iff (rst)
    state.stopped |-> (state.pending == 3'd0) && (state.lead_bits == 8'd0))
    else $error("stopped scan holds a partial character");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && scan_bytes.last_byte |=> (state == '0))
    else $error("scan state not cleared after buffer end");

  a_done_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_q.scan_done == (res_q.stop_reason != REASON_RUNNING)))
    else $error("done flag disagrees with stop reason");

  a_hold_length: assert property (@(posedge clk) disable iff (rst)
    accept && state.stopped && !scan_bytes.last_byte
    |=> (res_q.valid_length == $past(state.committed)) && (state == $past(state)))
    else $error("stopped scan changed its length");
`endif

endmodule

// ----- rtl/utf8v_step.sv -----
// utf8v_step: next scan state and result for one byte, pure logic.
// Depends on utf8v_pkg.
module utf8v_step import utf8v_pkg::*; #(
  parameter logic [LenW:0] LEN_CAP = 17'd65535
) (
  input  scan_state_t  cur,
  input  scan_cfg_t    cfg,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output scan_state_t  nxt,
  output scan_result_t res
);

  scan_state_t   s;
  logic          completed;
  logic [LenW:0] pos;
  logic          at_end;
  logic [7:0]    shifted;

  assign pos     = {1'b0, cur.committed} + {{(LenW-2){1'b0}}, cur.pending} + {{LenW{1'b0}}, 1'b1};
  assign at_end  = last_byte || (pos >= LEN_CAP);
  assign shifted = {cur.lead_bits[6:0], 1'b0};

  function automatic scan_state_t stop_with(scan_state_t st, stop_reason_t r);
    scan_state_t o;
    o           = st;
    o.stopped   = 1'b1;
    o.reason    = r;
    o.pending   = 3'd0;
    o.lead_bits = 8'd0;
    return o;
  endfunction

  always_comb begin
    s         = cur;
    completed = 1'b0;
    if (!cur.stopped) begin
      if (cur.pending == 3'd0) begin
        priority if (cfg.limit_by_chars && (cur.char_count >= cfg.char_limit)) begin
          s = stop_with(s, REASON_CHAR_LIM);
        end else if ((data_byte & TopBit) == 8'd0) begin
          if ((data_byte < CtrlTop) && cfg.control_mask[data_byte[4:0]]) begin
            s = stop_with(s, REASON_CONTROL);
          end else begin
            s.pending = 3'd1;
            completed = 1'b1;
          end
        end else if ((data_byte & LeadBits) != LeadBits) begin
          s = stop_with(s, REASON_MALFORMED);
        end else begin
          s.pending   = 3'd1;
          s.lead_bits = data_byte;
        end
      end else begin
        if ((cur.pending >= MaxBytes) || ((data_byte & LeadBits) != TopBit)) begin
          s = stop_with(s, REASON_MALFORMED);
        end else begin
          s.pending   = cur.pending + 3'd1;
          s.lead_bits = shifted;
          completed   = ((shifted & ContBit) == 8'd0);
        end
      end

      if (completed) begin
        s.committed  = s.committed + {{(LenW-3){1'b0}}, s.pending};
        s.char_count = s.char_count + {{(CountW-1){1'b0}}, 1'b1};
        s.pending    = 3'd0;
        s.lead_bits  = 8'd0;
        if (cfg.limit_by_chars && (s.char_count >= cfg.char_limit)) begin
          s = stop_with(s, REASON_CHAR_LIM);
        end
      end

      if (!s.stopped && at_end) begin
        s = stop_with(s, REASON_BUF_END);
      end
    end

    res.valid_length = s.committed;
    res.scan_done    = s.stopped;
    res.stop_reason  = s.reason;
    res.buffer_end   = last_byte;

    if (last_byte) begin
      nxt = '0;
    end else begin
      nxt = s;
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for utf8_prefix_validator_core, byte and result
// channels with random gaps and stalls, checked against an in-bench scan model.
// Depends on utf8v_pkg, utf8v_if and the core RTL.
module tb_top;
  import utf8v_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BufCap     = 65535;
  localparam int unsigned CycleLimit = 2_000_000;

  typedef logic [7:0] byte_seq_t[$];

  logic clk;
  logic rst;

  utf8v_byte_if   scan_bytes ();
  utf8v_result_if scan_results ();
  utf8v_cfg_if    cfg ();

  utf8_prefix_validator_core #(.MAX_BUFFER_BYTES(BufCap)) uut (
    .clk          (clk),
    .rst          (rst),
    .scan_bytes   (scan_bytes),
    .scan_results (scan_results),
    .cfg          (cfg)
  );

  // scan model state and register copies
  logic         scan_halted;
  logic [15:0]  good_len;
  logic [2:0]   open_bytes;
  logic [7:0]   lead_shift;
  logic [15:0]  good_chars;
  stop_reason_t halt_reason;
  logic [31:0]  ctrl_mask;
  logic         count_chars;
  logic [15:0]  max_chars;

  scan_result_t length_reports[$];
  logic [7:0]   char_bytes[$];
  int unsigned  live_bytes;
  int unsigned  results_seen;
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  logic         quiet;
  logic         byte_armed;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void clear_scan();
    scan_halted = 1'b0;
    good_len    = '0;
    open_bytes  = '0;
    lead_shift  = '0;
    good_chars  = '0;
    halt_reason = REASON_RUNNING;
  endfunction

  function automatic void halt_scan(stop_reason_t why);
    scan_halted = 1'b1;
    halt_reason = why;
    open_bytes  = '0;
    lead_shift  = '0;
  endfunction

  function automatic scan_result_t scan_next_byte(logic [7:0] b, logic is_last);
    scan_result_t r;
    int unsigned  pos;
    logic         at_end;
    logic         char_done;
    if (!scan_halted) begin
      pos = 32'(good_len) + 32'(open_bytes) + 1;
      at_end = is_last || pos >= BufCap;
      char_done = 1'b0;
      if (open_bytes == 0) begin
        if (count_chars && good_chars >= max_chars) begin
          halt_scan(REASON_CHAR_LIM);
        end else if (!b[7]) begin
          if (b < 8'h20 && ctrl_mask[b[4:0]]) begin
            halt_scan(REASON_CONTROL);
          end else begin
            open_bytes = 3'd1;
            char_done = 1'b1;
          end
        end else if (b[7:6] != 2'b11) begin
          halt_scan(REASON_MALFORMED);
        end else begin
          open_bytes = 3'd1;
          lead_shift = b;
        end
      end else if (open_bytes >= 3'd4 || b[7:6] != 2'b10) begin
        halt_scan(REASON_MALFORMED);
      end else begin
        open_bytes++;
        lead_shift = lead_shift << 1;
        if (!lead_shift[6]) char_done = 1'b1;
      end
      if (char_done) begin
        good_len = good_len + 16'(open_bytes);
        good_chars++;
        open_bytes = '0;
        lead_shift = '0;
        if (count_chars && good_chars >= max_chars) halt_scan(REASON_CHAR_LIM);
      end
      if (!scan_halted && at_end) halt_scan(REASON_BUF_END);
    end
    r.valid_length = good_len;
    r.scan_done    = scan_halted;
    r.stop_reason  = halt_reason;
    r.buffer_end   = is_last;
    if (is_last) clear_scan();
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("[%0t] result %0d: %s got %0h, expected %0h",
               $time, results_seen, what, got, want);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    scan_results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        scan_results.ready <= 1'b0;
        stall_left--;
      end else begin
        scan_results.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (!rst && scan_results.valid && scan_results.ready) begin
      results_seen++;
      if (length_reports.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(scan_results.valid_length), '0);
      end else begin
        want = length_reports.pop_front();
        if (scan_results.valid_length !== want.valid_length)
          report_mismatch("valid_length", 32'(scan_results.valid_length),
                          32'(want.valid_length));
        if (scan_results.scan_done !== want.scan_done)
          report_mismatch("scan_done", 32'(scan_results.scan_done), 32'(want.scan_done));
        if (scan_results.stop_reason !== want.stop_reason)
          report_mismatch("stop_reason", 32'(scan_results.stop_reason),
                          32'(want.stop_reason));
        if (scan_results.buffer_end !== want.buffer_end)
          report_mismatch("buffer_end", 32'(scan_results.buffer_end), 32'(want.buffer_end));
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      scan_bytes.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_bytes.valid     <= 1'b1;
    scan_bytes.data_byte <= value;
    scan_bytes.last_byte <= is_last;
    byte_armed = 1'b1;
    do @(posedge clk); while (!scan_bytes.ready);
    live_bytes++;
    length_reports.push_back(scan_next_byte(value, is_last));
  endtask

  task automatic send_buffer(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  task automatic drain_results();
    if (byte_armed) begin
      scan_bytes.valid <= 1'b0;
      byte_armed = 1'b0;
    end
    while (length_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_CONTROL_MASK:   ctrl_mask = value;
      CFG_LIMIT_BY_CHARS: count_chars = value[0];
      CFG_CHAR_LIMIT:     max_chars = value[15:0];
      default: ;
    endcase
  endtask

  // registers change only with the result channel drained
  task automatic apply_settings(logic [31:0] mask, logic by_chars, logic [15:0] lim);
    drain_results();
    write_reg(CFG_CONTROL_MASK, mask);
    write_reg(CFG_LIMIT_BY_CHARS, {31'($urandom), by_chars});
    write_reg(CFG_CHAR_LIMIT, {16'($urandom), lim});
    cfg.valid <= 1'b0;
  endtask

  task automatic randomize_settings();
    logic [31:0] mask;
    logic [15:0] lim;
    int unsigned roll;
    case ($urandom_range(0, 3))
      0:       mask = '0;
      1:       mask = '1;
      2:       mask = $urandom;
      default: mask = 32'h1 << $urandom_range(0, 31);
    endcase
    roll = $urandom_range(0, 9);
    if (roll < 6)      lim = 16'($urandom_range(0, 12));
    else if (roll < 9) lim = 16'($urandom_range(13, 200));
    else               lim = 16'($urandom_range(0, 65535));
    apply_settings(mask, 1'($urandom_range(0, 1)), lim);
  endtask

  function automatic logic [7:0] trail_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic logic [7:0] lead_byte(int unsigned trails);
    case (trails)
      1:       return {3'b110, 5'($urandom_range(0, 31))};
      2:       return {4'b1110, 4'($urandom_range(0, 15))};
      default: return {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  task automatic build_char();
    int unsigned roll;
    int unsigned trails;
    roll = $urandom_range(0, 99);
    char_bytes.delete();
    if (roll < 30) begin
      char_bytes.push_back(8'($urandom_range(32, 127)));
    end else if (roll < 36) begin
      char_bytes.push_back(8'($urandom_range(0, 31)));
    end else if (roll < 74) begin
      trails = roll < 52 ? 1 : (roll < 64 ? 2 : 3);
      char_bytes.push_back(lead_byte(trails));
      repeat (trails) char_bytes.push_back(trail_byte());
    end else if (roll < 80) begin
      // five-byte lead, payload arbitrary
      char_bytes.push_back({5'b11111, 3'($urandom_range(0, 7))});
      repeat (4) char_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (roll < 88) begin
      // cut short by a non-trail byte
      trails = $urandom_range(1, 3);
      char_bytes.push_back(lead_byte(trails));
      repeat ($urandom_range(0, trails - 1)) char_bytes.push_back(trail_byte());
      if ($urandom_range(0, 1) == 0) char_bytes.push_back(8'($urandom_range(0, 127)));
      else                           char_bytes.push_back(8'($urandom_range(192, 255)));
    end else begin
      char_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_well_formed();
    apply_settings('0, 1'b0, '0);
    send_buffer('{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hE2, 8'h82, 8'hAC,
                  8'hF0, 8'h9F, 8'h98, 8'h80});
    send_buffer('{8'hE2, 8'h82});
  endtask

  task automatic test_masked_control();
    apply_settings('1, 1'b0, '0);
    send_buffer('{8'h41, 8'h1F, 8'h42});
  endtask

  task automatic test_malformed();
    apply_settings('0, 1'b0, '0);
    send_buffer('{8'h80});
    send_buffer('{8'hC3, 8'h41});
    send_buffer('{8'hFF, 8'h80, 8'h80, 8'h80, 8'h00});
  endtask

  task automatic test_char_limit();
    apply_settings('0, 1'b1, 16'd0);
    send_buffer('{8'h41});
    apply_settings('0, 1'b1, 16'd2);
    send_buffer('{8'h41, 8'hC2, 8'h80});
    apply_settings('0, 1'b1, 16'd5);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    apply_settings('0, 1'b1, 16'd1);
    send_byte(8'h43, 1'b0);
    send_byte(8'h44, 1'b1);
  endtask

  task automatic test_random_buffers();
    int unsigned target;
    int unsigned n_chars;
    target = live_bytes + 1150;
    while (live_bytes < target) begin
      if ($urandom_range(0, 3) == 0) randomize_settings();
      quiet = ($urandom_range(0, 6) == 0);
      n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      for (int c = 0; c < n_chars; c++) begin
        if (c != 0 && $urandom_range(0, 39) == 0) randomize_settings();
        build_char();
        foreach (char_bytes[k])
          send_byte(char_bytes[k], c == n_chars - 1 && k == char_bytes.size() - 1);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst                  <= 1'b1;
    scan_bytes.valid     <= 1'b0;
    scan_bytes.data_byte <= '0;
    scan_bytes.last_byte <= 1'b0;
    cfg.valid            <= 1'b0;
    cfg.index            <= CFG_CONTROL_MASK;
    cfg.data             <= '0;
    quiet          = 1'b0;
    byte_armed     = 1'b0;
    live_bytes     = 0;
    results_seen   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    ctrl_mask      = '0;
    count_chars    = 1'b0;
    max_chars      = '0;
    clear_scan();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_well_formed();
    test_masked_control();
    test_malformed();
    test_char_limit();
    test_random_buffers();

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/utf8v_pkg.sv
rtl/utf8v_if.sv
rtl/utf8v_step.sv
rtl/utf8_prefix_validator_core.sv
bench/tb_top.sv
